/* design/bspm_pkg.sv */
// Shared types and constants for the batch slot pool manager.
// Used by bspm_slot_pool, bspm_counters and batch_slot_pool_manager.
`timescale 1ns / 1ps

package bspm_pkg;

    localparam int SLOT_COUNT = 8;
    // index width into the per-slot arrays (at least one bit)
    localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FILL_W     = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_ID_W  = 6;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        KIND_ACQUIRE = 2'd0,
        KIND_PUBLISH = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_STATS   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_BAD      = 3'd3,
        ST_SENDFAIL = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC   = 2'd0,
        CFG_VERSION = 2'd1,
        CFG_TYPE    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        kind_t       kind;
        logic        may_wait;
        logic [7:0]  slot;
        logic [31:0] seq_no;
        logic        send_ok;
        logic [7:0]  busy_retries;
        logic        length_ok;
        logic [31:0] msg_magic;
        logic [7:0]  msg_version;
        logic [7:0]  msg_type;
    } req_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [7:0]  version;
        logic [7:0]  type_code;
    } cfg_t;

    // counter update requests from the slot pool
    typedef struct packed {
        logic       sent_inc;
        logic [7:0] busy_add;
        logic       failed_inc;
        logic       released_inc;
        logic       bad_inc;
        logic       wait_inc;
    } evt_t;

    typedef struct packed {
        logic [CNT_W-1:0] sent;
        logic [CNT_W-1:0] busy;
        logic [CNT_W-1:0] failed;
        logic [CNT_W-1:0] released;
        logic [CNT_W-1:0] bad;
        logic [CNT_W-1:0] waits;
    } cnt_t;

endpackage

/* design/bspm_slot_pool.sv */
// Free-slot FIFO, per-slot in-flight flags and sequence numbers.
// Decides status and counter events for one transaction. Depends on bspm_pkg.
`timescale 1ns / 1ps

module bspm_slot_pool (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  bspm_pkg::req_t                  req,
    input  bspm_pkg::cfg_t                  cfg,
    output bspm_pkg::status_t               status,
    output logic [bspm_pkg::SLOT_ID_W-1:0]  granted,
    output bspm_pkg::evt_t                  evt
);

    localparam int TAIL_W = bspm_pkg::SLOT_IW + 1;
    localparam logic [TAIL_W-1:0] N_T = TAIL_W'(bspm_pkg::SLOT_COUNT);

    logic [bspm_pkg::SLOT_ID_W-1:0] fifo_reg [bspm_pkg::SLOT_COUNT];
    logic [bspm_pkg::SLOT_IW-1:0]   head_reg, head_next;
    logic [bspm_pkg::FILL_W-1:0]    fill_reg, fill_next;
    logic                           in_flight_reg [bspm_pkg::SLOT_COUNT];
    logic [31:0]                    seq_reg [bspm_pkg::SLOT_COUNT];

    logic [bspm_pkg::SLOT_IW-1:0] slot_idx;
    logic [bspm_pkg::SLOT_IW-1:0] tail;
    logic [TAIL_W-1:0]            tail_sum;
    logic                         slot_ok, fifo_full, rel_good;
    logic                         pop, push, seq_we, flight_set, flight_clr;

    assign slot_idx  = req.slot[bspm_pkg::SLOT_IW-1:0];
    assign slot_ok   = req.slot < 8'(bspm_pkg::SLOT_COUNT);
    assign fifo_full = fill_reg == bspm_pkg::FILL_W'(bspm_pkg::SLOT_COUNT);
    assign tail_sum  = TAIL_W'(head_reg) + TAIL_W'(fill_reg);
    assign tail      = (tail_sum >= N_T) ? bspm_pkg::SLOT_IW'(tail_sum - N_T)
                                         : bspm_pkg::SLOT_IW'(tail_sum);

    assign rel_good = req.length_ok
                   && (req.msg_magic == cfg.magic)
                   && (req.msg_version == cfg.version)
                   && (req.msg_type == cfg.type_code)
                   && slot_ok
                   && in_flight_reg[slot_idx]
                   && (seq_reg[slot_idx] == req.seq_no);

    always_comb
    begin
        status     = bspm_pkg::ST_OK;
        granted    = '0;
        evt        = '0;
        pop        = 1'b0;
        push       = 1'b0;
        seq_we     = 1'b0;
        flight_set = 1'b0;
        flight_clr = 1'b0;
        case (req.kind)
            bspm_pkg::KIND_ACQUIRE:
            begin
                if (fill_reg != '0)
                begin
                    pop     = 1'b1;
                    granted = fifo_reg[head_reg];
                end
                else
                begin
                    status       = bspm_pkg::ST_EMPTY;
                    evt.wait_inc = req.may_wait;
                end
            end
            bspm_pkg::KIND_PUBLISH:
            begin
                if (!slot_ok)
                begin
                    status = bspm_pkg::ST_RANGE;
                end
                else
                begin
                    seq_we       = 1'b1;
                    evt.busy_add = req.busy_retries;
                    if (req.send_ok)
                    begin
                        flight_set   = 1'b1;
                        evt.sent_inc = 1'b1;
                    end
                    else
                    begin
                        // failed send goes back to the pool; dropped if full
                        flight_clr     = 1'b1;
                        push           = !fifo_full;
                        evt.failed_inc = 1'b1;
                        status         = bspm_pkg::ST_SENDFAIL;
                    end
                end
            end
            bspm_pkg::KIND_RELEASE:
            begin
                if (!rel_good)
                begin
                    evt.bad_inc = 1'b1;
                    status      = bspm_pkg::ST_BAD;
                end
                else
                begin
                    flight_clr = 1'b1;
                    if (!fifo_full)
                    begin
                        push             = 1'b1;
                        evt.released_inc = 1'b1;
                    end
                    else
                    begin
                        evt.bad_inc = 1'b1;
                        status      = bspm_pkg::ST_BAD;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (en && pop)
        begin
            head_next = (head_reg == bspm_pkg::SLOT_IW'(bspm_pkg::SLOT_COUNT - 1))
                      ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
        else if (en && push)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= bspm_pkg::FILL_W'(bspm_pkg::SLOT_COUNT);
            for (int i = 0; i < bspm_pkg::SLOT_COUNT; i++)
            begin
                fifo_reg[i]      <= bspm_pkg::SLOT_ID_W'(i);
                in_flight_reg[i] <= 1'b0;
                seq_reg[i]       <= '0;
            end
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            if (en && push)
            begin
                fifo_reg[tail] <= req.slot[bspm_pkg::SLOT_ID_W-1:0];
            end
            if (en && seq_we)
            begin
                seq_reg[slot_idx] <= req.seq_no;
            end
            if (en && flight_set)
            begin
                in_flight_reg[slot_idx] <= 1'b1;
            end
            else if (en && flight_clr)
            begin
                in_flight_reg[slot_idx] <= 1'b0;
            end
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= bspm_pkg::FILL_W'(bspm_pkg::SLOT_COUNT))
        else $error("free fill above slot count");

    a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
        en && pop |=> fill_reg == $past(fill_reg) - 1'b1)
        else $error("pop did not drop the fill");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(en && (pop || push)) |=> $stable(fill_reg) && $stable(head_reg))
        else $error("FIFO pointers moved without a pop or push");

    a_flight_set: assert property (@(posedge clk) disable iff (!rst_n)
        en && flight_set |=> in_flight_reg[$past(slot_idx)])
        else $error("successful publish did not mark the slot in flight");

endmodule

/* design/bspm_counters.sv */
// Six wrapping 32-bit statistics counters.
// Bumped from slot pool events; depends on bspm_pkg.
`timescale 1ns / 1ps

module bspm_counters (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  bspm_pkg::evt_t evt,
    output bspm_pkg::cnt_t cnt
);

    bspm_pkg::cnt_t cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (en)
        begin
            cnt_next.sent     = cnt_reg.sent + bspm_pkg::CNT_W'(evt.sent_inc);
            cnt_next.busy     = cnt_reg.busy + bspm_pkg::CNT_W'(evt.busy_add);
            cnt_next.failed   = cnt_reg.failed + bspm_pkg::CNT_W'(evt.failed_inc);
            cnt_next.released = cnt_reg.released + bspm_pkg::CNT_W'(evt.released_inc);
            cnt_next.bad      = cnt_reg.bad + bspm_pkg::CNT_W'(evt.bad_inc);
            cnt_next.waits    = cnt_reg.waits + bspm_pkg::CNT_W'(evt.wait_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign cnt = cnt_reg;

endmodule

/* design/batch_slot_pool_manager.sv */
// Top level of the batch slot pool manager: input register, config registers,
// slot pool, counters and result register. Depends on bspm_pkg,
// bspm_slot_pool and bspm_counters.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  request | in_valid/in_ready + request fields   | in
//  result  | out_valid/out_ready + result fields  | out
//  config  | cfg_we, cfg_index, cfg_data          | in, write only
//
// A transaction lands in the input register, is processed by the slot pool and
// counters, and its result is loaded into the output register. Throughput is
// one transaction per cycle while out_ready is high; out_valid rises once the
// accepted transaction has passed the input register and reached the output register.
// A result held by out_ready low stalls the input register, which holds one
// transaction; in_ready drops only when both are full and out_ready is low.
// Reset fills the free FIFO with slots 0..N-1 and clears all counters.
`timescale 1ns / 1ps

module batch_slot_pool_manager (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bspm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          kind,
    input  logic                                may_wait,
    input  logic [7:0]                          slot,
    input  logic [31:0]                         seq_no,
    input  logic                                send_ok,
    input  logic [7:0]                          busy_retries,
    input  logic                                length_ok,
    input  logic [31:0]                         msg_magic,
    input  logic [7:0]                          msg_version,
    input  logic [7:0]                          msg_type,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          status,
    output logic [bspm_pkg::SLOT_ID_W-1:0]      granted_slot,
    output logic [31:0]                         sent_count,
    output logic [31:0]                         busy_count,
    output logic [31:0]                         failed_count,
    output logic [31:0]                         released_count,
    output logic [31:0]                         bad_release_count,
    output logic [31:0]                         wait_count
);

    bspm_pkg::cfg_t  cfg_reg;
    bspm_pkg::req_t  req_reg;
    logic            req_valid_reg;
    logic            out_valid_reg;
    bspm_pkg::status_t              status_reg;
    logic [bspm_pkg::SLOT_ID_W-1:0] granted_reg;
    bspm_pkg::cnt_t                 stats_reg;

    bspm_pkg::status_t              pool_status;
    logic [bspm_pkg::SLOT_ID_W-1:0] pool_granted;
    bspm_pkg::evt_t                 evt;
    bspm_pkg::cnt_t                 cnt;
    logic                           advance;

    assign advance  = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bspm_pkg::CFG_MAGIC:   cfg_reg.magic     <= cfg_data;
                bspm_pkg::CFG_VERSION: cfg_reg.version   <= cfg_data[7:0];
                bspm_pkg::CFG_TYPE:    cfg_reg.type_code <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.kind         <= bspm_pkg::kind_t'(kind);
            req_reg.may_wait     <= may_wait;
            req_reg.slot         <= slot;
            req_reg.seq_no       <= seq_no;
            req_reg.send_ok      <= send_ok;
            req_reg.busy_retries <= busy_retries;
            req_reg.length_ok    <= length_ok;
            req_reg.msg_magic    <= msg_magic;
            req_reg.msg_version  <= msg_version;
            req_reg.msg_type     <= msg_type;
        end
    end

    bspm_slot_pool u_pool (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .req     (req_reg),
        .cfg     (cfg_reg),
        .status  (pool_status),
        .granted (pool_granted),
        .evt     (evt)
    );

    bspm_counters u_counters (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .evt   (evt),
        .cnt   (cnt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg  <= pool_status;
            granted_reg <= pool_granted;
            // stats are reported only on a read-stats transaction
            stats_reg   <= (req_reg.kind == bspm_pkg::KIND_STATS) ? cnt : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign granted_slot      = granted_reg;
    assign sent_count        = stats_reg.sent;
    assign busy_count        = stats_reg.busy;
    assign failed_count      = stats_reg.failed;
    assign released_count    = stats_reg.released;
    assign bad_release_count = stats_reg.bad;
    assign wait_count        = stats_reg.waits;

endmodule
